[design/engine_telegraph_sentence_parser_top_macros.svh]
// assertion macros for the engine telegraph sentence parser
// expects clk and rst_n in the scope where a macro is used
`ifndef ENGINE_TELEGRAPH_SENTENCE_PARSER_TOP_MACROS_SVH
`define ENGINE_TELEGRAPH_SENTENCE_PARSER_TOP_MACROS_SVH

// same-cycle implication, held off during reset
`define ETSP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define ETSP_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/etsp_pkg.sv]
// shared types for the engine telegraph sentence parser
// no dependencies; used by the interfaces and all modules
package etsp_pkg;

    // result status codes
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_TIME      = 3'd1,
        ST_TYPE      = 3'd2,
        ST_TELEGRAPH = 3'd3,
        ST_SUB       = 3'd4,
        ST_LOCATION  = 3'd5,
        ST_SHAFT     = 3'd6
    } status_t;

    // field being parsed
    typedef enum logic [2:0] {
        FLD_TIME      = 3'd0,
        FLD_TYPE      = 3'd1,
        FLD_TELEGRAPH = 3'd2,
        FLD_SUB       = 3'd3,
        FLD_LOCATION  = 3'd4,
        FLD_SHAFT     = 3'd5
    } field_t;

    // one input character
    typedef struct packed {
        logic [7:0] character;
        logic       start_of_sentence;
        logic       end_of_sentence;
    } in_item_t;

    // one parse result
    typedef struct packed {
        status_t    status;
        logic       time_present;
        logic [6:0] hours;
        logic [6:0] minutes;
        logic [6:0] seconds;
        logic [6:0] hundredths;
        logic       is_answerback;
        logic       telegraph_side;
        logic [2:0] telegraph_position;
        logic [5:0] sub_position;
        logic [2:0] location_code;
        logic [3:0] shaft_number;
    } out_item_t;

endpackage

[design/etsp_in_if.sv]
// input character channel: valid/ready handshake with the character payload
// depends on etsp_pkg
interface etsp_in_if;
    logic             valid;
    logic             ready;
    etsp_pkg::in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[design/etsp_out_if.sv]
// result channel: valid/ready handshake with the parse result payload
// depends on etsp_pkg
interface etsp_out_if;
    logic              valid;
    logic              ready;
    etsp_pkg::out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[design/etsp_in_reg.sv]
// input register: captures one character transaction per cycle while its slot is empty or being consumed
// depends on etsp_pkg
module etsp_in_reg (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  etsp_pkg::in_item_t in_data,
    input  logic               advance,
    output logic               item_valid,
    output etsp_pkg::in_item_t item
);

    logic               valid_reg;
    logic               valid_next;
    etsp_pkg::in_item_t item_reg;

    // slot frees when the parser consumes the held character
    assign in_ready   = !valid_reg || advance;
    assign valid_next = in_ready ? in_valid : valid_reg;

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_data;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

[design/etsp_parse.sv]
// per-character parse step: field state registers and result decision
// depends on etsp_pkg and the assertion macro header
`include "engine_telegraph_sentence_parser_top_macros.svh"

module etsp_parse (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    input  etsp_pkg::in_item_t  item,
    input  logic                advance,
    output logic                res_valid,
    output etsp_pkg::out_item_t res
);

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_TWO   = 8'h32;
    localparam logic [7:0] CH_FOUR  = 8'h34;
    localparam logic [7:0] CH_FIVE  = 8'h35;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_O     = 8'h4F;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_B     = 8'h42;
    localparam logic [7:0] CH_C     = 8'h43;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_W     = 8'h57;

    localparam logic [2:0] LOC_B = 3'd1;
    localparam logic [2:0] LOC_C = 3'd2;
    localparam logic [2:0] LOC_P = 3'd3;
    localparam logic [2:0] LOC_S = 3'd4;
    localparam logic [2:0] LOC_E = 3'd5;
    localparam logic [2:0] LOC_W = 3'd6;

    localparam logic [3:0] TIME_LEN  = 4'd9;
    localparam logic [3:0] COUNT_MAX = 4'd15;

    // whether a field may close with n characters
    function automatic logic field_complete(etsp_pkg::field_t f, logic [3:0] n);
        logic ok;
        ok = 1'b0;
        unique case (f)
            etsp_pkg::FLD_TIME:      ok = (n == 4'd0) || (n == TIME_LEN);
            etsp_pkg::FLD_TYPE:      ok = (n == 4'd1);
            etsp_pkg::FLD_TELEGRAPH: ok = (n == 4'd2);
            etsp_pkg::FLD_SUB:       ok = (n == 4'd2);
            etsp_pkg::FLD_LOCATION:  ok = (n <= 4'd1);
            etsp_pkg::FLD_SHAFT:     ok = (n == 4'd1);
            default:                 ok = 1'b0;
        endcase
        return ok;
    endfunction

    // status naming a field that failed
    function automatic etsp_pkg::status_t fail_status(etsp_pkg::field_t f);
        return etsp_pkg::status_t'(3'(f + 3'd1));
    endfunction

    // digit times ten
    function automatic logic [6:0] times_ten(logic [3:0] d);
        return 7'({3'b000, d} << 3) + 7'({3'b000, d} << 1);
    endfunction

    etsp_pkg::field_t field_reg, field_next;
    logic [3:0] count_reg, count_next;
    logic       ignoring_reg, ignoring_next;
    logic [2:0] held_reg, held_next;
    logic [6:0] hours_reg, hours_next;
    logic [6:0] minutes_reg, minutes_next;
    logic [6:0] seconds_reg, seconds_next;
    logic [6:0] hundredths_reg, hundredths_next;
    logic       answer_reg, answer_next;
    logic       side_reg, side_next;
    logic [2:0] position_reg, position_next;
    logic [5:0] sub_reg, sub_next;
    logic [2:0] location_reg, location_next;
    logic [3:0] shaft_reg, shaft_next;
    logic       time_seen_reg, time_seen_next;

    logic                fire;
    logic                have_res;
    etsp_pkg::status_t   res_code;
    logic [7:0]          c;
    logic [3:0]          d;
    logic                is_dig;
    logic                sep;
    logic                ok;
    logic [6:0]          tens;

    assign fire   = item_valid && advance;
    assign c      = item.character;
    assign d      = 4'(c - CH_ZERO);
    assign is_dig = (c >= CH_ZERO) && (c <= CH_NINE);
    assign tens   = times_ten(d);

    // one parse step on the held character
    always_comb
    begin
        if (item.start_of_sentence)
        begin
            field_next      = etsp_pkg::FLD_TIME;
            count_next      = 4'd0;
            ignoring_next   = 1'b0;
            held_next       = 3'd0;
            hours_next      = 7'd0;
            minutes_next    = 7'd0;
            seconds_next    = 7'd0;
            hundredths_next = 7'd0;
            answer_next     = 1'b0;
            side_next       = 1'b0;
            position_next   = 3'd0;
            sub_next        = 6'd0;
            location_next   = 3'd0;
            shaft_next      = 4'd0;
            time_seen_next  = 1'b0;
        end
        else
        begin
            field_next      = field_reg;
            count_next      = count_reg;
            ignoring_next   = ignoring_reg;
            held_next       = held_reg;
            hours_next      = hours_reg;
            minutes_next    = minutes_reg;
            seconds_next    = seconds_reg;
            hundredths_next = hundredths_reg;
            answer_next     = answer_reg;
            side_next       = side_reg;
            position_next   = position_reg;
            sub_next        = sub_reg;
            location_next   = location_reg;
            shaft_next      = shaft_reg;
            time_seen_next  = time_seen_reg;
        end

        have_res = 1'b0;
        res_code = etsp_pkg::ST_OK;
        ok       = 1'b0;
        sep      = ((field_next != etsp_pkg::FLD_SHAFT) && (c == CH_COMMA)) ||
                   ((field_next == etsp_pkg::FLD_SHAFT) && (c == CH_STAR));

        if (!ignoring_next)
        begin
            if (sep)
            begin
                // separator closes the current field
                if (!field_complete(field_next, count_next))
                begin
                    have_res = 1'b1;
                    res_code = fail_status(field_next);
                end
                else if (field_next == etsp_pkg::FLD_SHAFT)
                begin
                    have_res = 1'b1;
                    res_code = etsp_pkg::ST_OK;
                end
                else
                begin
                    if (field_next == etsp_pkg::FLD_TIME)
                    begin
                        time_seen_next = (count_next == TIME_LEN);
                    end
                    field_next = etsp_pkg::field_t'(3'(field_next + 3'd1));
                    count_next = 4'd0;
                end
            end
            else
            begin
                // character inside a field
                unique case (field_next)
                    etsp_pkg::FLD_TIME:
                    begin
                        if (count_next == 4'd6)
                        begin
                            ok = (c == CH_DOT);
                        end
                        else if ((count_next > 4'd8) || !is_dig)
                        begin
                            ok = 1'b0;
                        end
                        else
                        begin
                            ok = 1'b1;
                            case (count_next)
                                4'd0:    hours_next = tens;
                                4'd1:    hours_next = hours_next + 7'(d);
                                4'd2:    minutes_next = tens;
                                4'd3:    minutes_next = minutes_next + 7'(d);
                                4'd4:    seconds_next = tens;
                                4'd5:    seconds_next = seconds_next + 7'(d);
                                4'd7:    hundredths_next = tens;
                                4'd8:    hundredths_next = hundredths_next + 7'(d);
                                default: ok = 1'b1;
                            endcase
                        end
                    end
                    etsp_pkg::FLD_TYPE:
                    begin
                        ok = (count_next == 4'd0) && ((c == CH_O) || (c == CH_A));
                        if (ok)
                        begin
                            answer_next = (c == CH_A);
                        end
                    end
                    etsp_pkg::FLD_TELEGRAPH:
                    begin
                        if ((count_next == 4'd0) && ((c == CH_ZERO) || (c == CH_ONE)))
                        begin
                            ok        = 1'b1;
                            side_next = d[0];
                        end
                        else if ((count_next == 4'd1) && (c >= CH_ONE) && (c <= CH_FIVE))
                        begin
                            ok            = 1'b1;
                            position_next = d[2:0];
                        end
                    end
                    etsp_pkg::FLD_SUB:
                    begin
                        if ((count_next == 4'd0) && (c >= CH_TWO) && (c <= CH_FOUR))
                        begin
                            ok        = 1'b1;
                            held_next = d[2:0];
                        end
                        else if ((count_next == 4'd1) && (c == CH_ZERO))
                        begin
                            ok       = 1'b1;
                            sub_next = 6'(times_ten({1'b0, held_next}));
                        end
                    end
                    etsp_pkg::FLD_LOCATION:
                    begin
                        if (count_next == 4'd0)
                        begin
                            ok = 1'b1;
                            case (c)
                                CH_B:    location_next = LOC_B;
                                CH_C:    location_next = LOC_C;
                                CH_P:    location_next = LOC_P;
                                CH_S:    location_next = LOC_S;
                                CH_E:    location_next = LOC_E;
                                CH_W:    location_next = LOC_W;
                                default: ok = 1'b0;
                            endcase
                        end
                    end
                    etsp_pkg::FLD_SHAFT:
                    begin
                        ok = (count_next == 4'd0) && is_dig;
                        if (ok)
                        begin
                            shaft_next = d;
                        end
                    end
                    default: ok = 1'b0;
                endcase

                if (!ok)
                begin
                    have_res = 1'b1;
                    res_code = fail_status(field_next);
                end
                else if (count_next < COUNT_MAX)
                begin
                    count_next = count_next + 4'd1;
                end
            end

            // end of sentence closes the current field
            if (!have_res && item.end_of_sentence)
            begin
                have_res = 1'b1;
                if (!field_complete(field_next, count_next))
                begin
                    res_code = fail_status(field_next);
                end
                else if (field_next == etsp_pkg::FLD_SHAFT)
                begin
                    res_code = etsp_pkg::ST_OK;
                end
                else
                begin
                    if (field_next == etsp_pkg::FLD_TIME)
                    begin
                        time_seen_next = (count_next == TIME_LEN);
                    end
                    res_code = etsp_pkg::status_t'(3'(field_next + 3'd2));
                end
            end

            if (have_res)
            begin
                ignoring_next = 1'b1;
            end
        end
    end

    // result fields, zero from the failing field onward
    always_comb
    begin
        logic k0, k1, k2, k3, k4, k5;
        k0 = (res_code == etsp_pkg::ST_OK) || (res_code > etsp_pkg::ST_TIME);
        k1 = (res_code == etsp_pkg::ST_OK) || (res_code > etsp_pkg::ST_TYPE);
        k2 = (res_code == etsp_pkg::ST_OK) || (res_code > etsp_pkg::ST_TELEGRAPH);
        k3 = (res_code == etsp_pkg::ST_OK) || (res_code > etsp_pkg::ST_SUB);
        k4 = (res_code == etsp_pkg::ST_OK) || (res_code > etsp_pkg::ST_LOCATION);
        k5 = (res_code == etsp_pkg::ST_OK);
        res.status             = res_code;
        res.time_present       = k0 ? time_seen_next : 1'b0;
        res.hours              = k0 ? hours_next : 7'd0;
        res.minutes            = k0 ? minutes_next : 7'd0;
        res.seconds            = k0 ? seconds_next : 7'd0;
        res.hundredths         = k0 ? hundredths_next : 7'd0;
        res.is_answerback      = k1 ? answer_next : 1'b0;
        res.telegraph_side     = k2 ? side_next : 1'b0;
        res.telegraph_position = k2 ? position_next : 3'd0;
        res.sub_position       = k3 ? sub_next : 6'd0;
        res.location_code      = k4 ? location_next : 3'd0;
        res.shaft_number       = k5 ? shaft_next : 4'd0;
    end

    assign res_valid = have_res;

    // parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_reg      <= etsp_pkg::FLD_TIME;
            count_reg      <= 4'd0;
            ignoring_reg   <= 1'b1;
            held_reg       <= 3'd0;
            hours_reg      <= 7'd0;
            minutes_reg    <= 7'd0;
            seconds_reg    <= 7'd0;
            hundredths_reg <= 7'd0;
            answer_reg     <= 1'b0;
            side_reg       <= 1'b0;
            position_reg   <= 3'd0;
            sub_reg        <= 6'd0;
            location_reg   <= 3'd0;
            shaft_reg      <= 4'd0;
            time_seen_reg  <= 1'b0;
        end
        else if (fire)
        begin
            field_reg      <= field_next;
            count_reg      <= count_next;
            ignoring_reg   <= ignoring_next;
            held_reg       <= held_next;
            hours_reg      <= hours_next;
            minutes_reg    <= minutes_next;
            seconds_reg    <= seconds_next;
            hundredths_reg <= hundredths_next;
            answer_reg     <= answer_next;
            side_reg       <= side_next;
            position_reg   <= position_next;
            sub_reg        <= sub_next;
            location_reg   <= location_next;
            shaft_reg      <= shaft_next;
            time_seen_reg  <= time_seen_next;
        end
    end

    // checks
    `ETSP_ASSERT_NXT(a_ignore_after_result, fire && have_res, ignoring_reg, "parser not idle after result")
    `ETSP_ASSERT_IMP(a_short_fields, field_reg != etsp_pkg::FLD_TIME, count_reg <= 4'd2, "field count overrun")
    `ETSP_ASSERT_IMP(a_time_count, field_reg == etsp_pkg::FLD_TIME, count_reg <= TIME_LEN, "time count overrun")

endmodule

[design/etsp_out_reg.sv]
// result register: holds one parse result until the receiver takes it
// depends on etsp_pkg and the assertion macro header
`include "engine_telegraph_sentence_parser_top_macros.svh"

module etsp_out_reg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  etsp_pkg::out_item_t res,
    output logic                advance,
    output logic                out_valid,
    input  logic                out_ready,
    output etsp_pkg::out_item_t out_data
);

    logic                valid_reg;
    logic                valid_next;
    etsp_pkg::out_item_t data_reg;

    // pipeline moves when the slot is empty or being emptied
    assign advance = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (advance)
        begin
            valid_next = load;
        end
    end

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (advance && load)
        begin
            data_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // checks
    `ETSP_ASSERT_IMP(a_fail_no_shaft, valid_reg && (data_reg.status != etsp_pkg::ST_OK), data_reg.shaft_number == 4'd0, "shaft set on failed sentence")
    `ETSP_ASSERT_IMP(a_ok_position, valid_reg && (data_reg.status == etsp_pkg::ST_OK), data_reg.telegraph_position != 3'd0, "ok result without position")
    `ETSP_ASSERT_IMP(a_ok_sub, valid_reg && (data_reg.status == etsp_pkg::ST_OK), data_reg.sub_position != 6'd0, "ok result without sub position")

endmodule

[design/engine_telegraph_sentence_parser_top.sv]
// Engine telegraph sentence parser, top level.
// Depends on etsp_pkg, etsp_in_if, etsp_out_if, etsp_in_reg, etsp_parse, etsp_out_reg.
//
// Usage:
//   in_ch carries one character of the sentence body per transaction, with
//   start_of_sentence on the first character and end_of_sentence on the last.
//   out_ch carries one result per sentence: at the end of the body or at the
//   first bad field. Characters after a result are dropped until the next start.
// Flow: a character taken into the input register is parsed when the parse stage
//   advances; a result it causes is then held in the result register for out_ch.
// Throughput: one character per cycle unless out_ch stalls; the parse step is a single
//   pass of compare logic between the input register and the result register.
// Reset: both registers empty, parser waits for a start character.
// Stall: while out_ch holds a result that is not taken, the parse stage halts;
//   the input register takes a character only while empty, then in_ch.ready drops.
module engine_telegraph_sentence_parser_top (
    input  logic              clk,
    input  logic              rst_n,
    etsp_in_if.sink           in_ch,
    etsp_out_if.source        out_ch
);

    logic                advance;
    logic                item_valid;
    etsp_pkg::in_item_t  item;
    logic                res_valid;
    etsp_pkg::out_item_t res;
    logic                in_ready;
    logic                out_valid;
    etsp_pkg::out_item_t out_data;

    // input register
    etsp_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_ch.valid),
        .in_ready   (in_ready),
        .in_data    (in_ch.data),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    // parse step
    etsp_parse u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .advance    (advance),
        .res_valid  (res_valid),
        .res        (res)
    );

    // result register
    etsp_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (item_valid && res_valid),
        .res       (res),
        .advance   (advance),
        .out_valid (out_valid),
        .out_ready (out_ch.ready),
        .out_data  (out_data)
    );

    assign in_ch.ready  = in_ready;
    assign out_ch.valid = out_valid;
    assign out_ch.data  = out_data;

endmodule
